FILE: sv/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg: shared widths, constants and types
// Fixed-point widths for the swept box collision pipeline.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int POS_W     = 32;   // signed Q16.16 centre
  localparam int HALF_W    = 31;   // unsigned Q15.16 half extent
  localparam int VEL_W     = 32;   // signed Q16.16 velocity
  localparam int DT_W      = 24;   // unsigned Q8.16 step
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = VEL_W + DT_W + 1;     // velocity * dt
  localparam int DISP_W    = 40;                   // displacement, Q24.16
  localparam int DREL_W    = DISP_W + 1;           // relative displacement
  localparam int EDGE_W    = POS_W + 1;            // box edge
  localparam int SPAN_W    = EDGE_W + 1;           // edge difference
  localparam int NUM_W     = SPAN_W;               // divider numerator
  localparam int DEN_W     = DREL_W;               // divider denominator
  localparam int REM_W     = DEN_W + 1;            // divider remainder
  localparam int Q_W       = 17;                   // Q1.16 time, 1.0 included
  localparam int DIV_STEPS = Q_W;                  // one quotient bit a stage
  localparam int CPROD_W   = DISP_W + Q_W + 1;     // displacement * time
  localparam int CSUM_W    = CPROD_W - FRAC_W + 1; // centre plus offset

  localparam logic [Q_W-1:0]  ONE_Q16  = 17'd65536;
  localparam logic [DT_W-1:0] DT_RESET = 24'd65536;

  // side data that travels alongside the dividers
  typedef struct packed {
    logic signed [POS_W-1:0]  pa_x;
    logic signed [POS_W-1:0]  pa_y;
    logic signed [POS_W-1:0]  pb_x;
    logic signed [POS_W-1:0]  pb_y;
    logic signed [DISP_W-1:0] da_x;
    logic signed [DISP_W-1:0] da_y;
    logic signed [DISP_W-1:0] db_x;
    logic signed [DISP_W-1:0] db_y;
    logic                     ov;          // overlap at time zero
    logic                     fail_static; // static axis separated or no motion
    logic                     act_x;
    logic                     act_y;
    logic                     sneg_x;
    logic                     eneg_x;
    logic                     sneg_y;
    logic                     eneg_y;
  } carry_t;

endpackage

FILE: sv/swept_box_collision_unit.sv
// ----------------------------------------------------------------------------
// swept_box_collision_unit: swept 2-D axis-aligned box collision
// Takes one pair per cycle while no finished result is held back by out_ready.
// Depth is set by the 17 one-bit-per-stage slab dividers plus six datapath stages.
// A stalled result freezes the whole pipeline; no item is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets time_step to 1.0.
// ----------------------------------------------------------------------------
module swept_box_collision_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [sbc_pkg::DT_W-1:0]           cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [sbc_pkg::POS_W-1:0]   in_a_pos_x,
  input  logic signed [sbc_pkg::POS_W-1:0]   in_a_pos_y,
  input  logic [sbc_pkg::HALF_W-1:0]         in_a_half_x,
  input  logic [sbc_pkg::HALF_W-1:0]         in_a_half_y,
  input  logic signed [sbc_pkg::VEL_W-1:0]   in_a_vel_x,
  input  logic signed [sbc_pkg::VEL_W-1:0]   in_a_vel_y,
  input  logic signed [sbc_pkg::POS_W-1:0]   in_b_pos_x,
  input  logic signed [sbc_pkg::POS_W-1:0]   in_b_pos_y,
  input  logic [sbc_pkg::HALF_W-1:0]         in_b_half_x,
  input  logic [sbc_pkg::HALF_W-1:0]         in_b_half_y,
  input  logic signed [sbc_pkg::VEL_W-1:0]   in_b_vel_x,
  input  logic signed [sbc_pkg::VEL_W-1:0]   in_b_vel_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic [sbc_pkg::Q_W-1:0]            out_hit_time,
  output logic signed [sbc_pkg::POS_W-1:0]   out_a_contact_x,
  output logic signed [sbc_pkg::POS_W-1:0]   out_a_contact_y,
  output logic signed [sbc_pkg::POS_W-1:0]   out_b_contact_x,
  output logic signed [sbc_pkg::POS_W-1:0]   out_b_contact_y
);

  localparam int PW  = sbc_pkg::POS_W;
  localparam int HW  = sbc_pkg::HALF_W;
  localparam int DSW = sbc_pkg::DISP_W;
  localparam int DRW = sbc_pkg::DREL_W;
  localparam int EW  = sbc_pkg::EDGE_W;
  localparam int SW  = sbc_pkg::SPAN_W;
  localparam int QW  = sbc_pkg::Q_W;
  localparam int FW  = sbc_pkg::FRAC_W;
  localparam int PRW = sbc_pkg::PROD_W;
  localparam int CPW = sbc_pkg::CPROD_W;
  localparam int CSW = sbc_pkg::CSUM_W;
  localparam int DS  = sbc_pkg::DIV_STEPS;
  // stages: A, B, C, dividers, E (time select), F (contact multiply), G (output)
  localparam int NSTG = DS + 6;

  // --------------------------------------------------------------------------
  // Configuration and pipeline control
  // --------------------------------------------------------------------------
  logic [sbc_pkg::DT_W-1:0] time_step_r;
  logic [NSTG-1:0]          v_r;
  logic                     en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= sbc_pkg::DT_RESET;
    end else if (cfg_wr_en) begin
      time_step_r <= cfg_wr_data;
    end
  end

  // every stage advances together unless a finished result is held back
  assign en       = !v_r[NSTG-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: displacement products velocity * dt
  // --------------------------------------------------------------------------
  localparam int DW_DT = sbc_pkg::DT_W;
  logic signed [PW-1:0]  a_pax_r, a_pay_r, a_pbx_r, a_pby_r;
  logic [HW-1:0]         a_hax_r, a_hay_r, a_hbx_r, a_hby_r;
  logic signed [PRW-1:0] a_pvax_r, a_pvay_r, a_pvbx_r, a_pvby_r;
  logic signed [DW_DT:0] dt_s;

  assign dt_s = $signed({1'b0, time_step_r});

  always_ff @(posedge clk) begin
    if (en) begin
      a_pax_r  <= in_a_pos_x;
      a_pay_r  <= in_a_pos_y;
      a_pbx_r  <= in_b_pos_x;
      a_pby_r  <= in_b_pos_y;
      a_hax_r  <= in_a_half_x;
      a_hay_r  <= in_a_half_y;
      a_hbx_r  <= in_b_half_x;
      a_hby_r  <= in_b_half_y;
      a_pvax_r <= PRW'(in_a_vel_x * dt_s);
      a_pvay_r <= PRW'(in_a_vel_y * dt_s);
      a_pvbx_r <= PRW'(in_b_vel_x * dt_s);
      a_pvby_r <= PRW'(in_b_vel_y * dt_s);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: floor shift, relative motion, box edges, centre gap
  // --------------------------------------------------------------------------
  logic signed [DSW-1:0] da_x, da_y, db_x, db_y;
  // product fits 56 bits, so bits [55:16] are the floored Q24.16 displacement
  assign da_x = a_pvax_r[DSW+FW-1:FW];
  assign da_y = a_pvay_r[DSW+FW-1:FW];
  assign db_x = a_pvbx_r[DSW+FW-1:FW];
  assign db_y = a_pvby_r[DSW+FW-1:FW];

  logic signed [PW-1:0]  b_pax_r, b_pay_r, b_pbx_r, b_pby_r;
  logic signed [DSW-1:0] b_dax_r, b_day_r, b_dbx_r, b_dby_r;
  logic signed [DRW-1:0] b_dx_r, b_dy_r;
  logic signed [EW-1:0]  b_aminx_r, b_amaxx_r, b_bminx_r, b_bmaxx_r;
  logic signed [EW-1:0]  b_aminy_r, b_amaxy_r, b_bminy_r, b_bmaxy_r;
  logic signed [EW-1:0]  b_gapx_r, b_gapy_r;
  logic [HW:0]           b_hsumx_r, b_hsumy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_pax_r   <= a_pax_r;
      b_pay_r   <= a_pay_r;
      b_pbx_r   <= a_pbx_r;
      b_pby_r   <= a_pby_r;
      b_dax_r   <= da_x;
      b_day_r   <= da_y;
      b_dbx_r   <= db_x;
      b_dby_r   <= db_y;
      b_dx_r    <= DRW'(db_x) - DRW'(da_x);
      b_dy_r    <= DRW'(db_y) - DRW'(da_y);
      b_aminx_r <= EW'(a_pax_r) - $signed({2'b00, a_hax_r});
      b_amaxx_r <= EW'(a_pax_r) + $signed({2'b00, a_hax_r});
      b_bminx_r <= EW'(a_pbx_r) - $signed({2'b00, a_hbx_r});
      b_bmaxx_r <= EW'(a_pbx_r) + $signed({2'b00, a_hbx_r});
      b_aminy_r <= EW'(a_pay_r) - $signed({2'b00, a_hay_r});
      b_amaxy_r <= EW'(a_pay_r) + $signed({2'b00, a_hay_r});
      b_bminy_r <= EW'(a_pby_r) - $signed({2'b00, a_hby_r});
      b_bmaxy_r <= EW'(a_pby_r) + $signed({2'b00, a_hby_r});
      b_gapx_r  <= EW'(a_pax_r) - EW'(a_pbx_r);
      b_gapy_r  <= EW'(a_pay_r) - EW'(a_pby_r);
      b_hsumx_r <= {1'b0, a_hax_r} + {1'b0, a_hbx_r};
      b_hsumy_r <= {1'b0, a_hay_r} + {1'b0, a_hby_r};
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: slab numerators, |d|, overlap now, static-axis separation
  // --------------------------------------------------------------------------
  logic          posx, posy, dzx, dzy;
  logic [EW-1:0] agapx, agapy;

  assign dzx  = (b_dx_r == '0);
  assign dzy  = (b_dy_r == '0);
  assign posx = !b_dx_r[DRW-1] && !dzx;
  assign posy = !b_dy_r[DRW-1] && !dzy;
  assign agapx = b_gapx_r[EW-1] ? EW'(-b_gapx_r) : EW'(b_gapx_r);
  assign agapy = b_gapy_r[EW-1] ? EW'(-b_gapy_r) : EW'(b_gapy_r);

  logic signed [PW-1:0]  c_pax_r, c_pay_r, c_pbx_r, c_pby_r;
  logic signed [DSW-1:0] c_dax_r, c_day_r, c_dbx_r, c_dby_r;
  logic signed [SW-1:0]  c_lox_r, c_hix_r, c_loy_r, c_hiy_r;
  logic [DRW-1:0]        c_ddx_r, c_ddy_r;
  logic                  c_dzx_r, c_dzy_r, c_sepx_r, c_sepy_r, c_ov_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_pax_r  <= b_pax_r;
      c_pay_r  <= b_pay_r;
      c_pbx_r  <= b_pbx_r;
      c_pby_r  <= b_pby_r;
      c_dax_r  <= b_dax_r;
      c_day_r  <= b_day_r;
      c_dbx_r  <= b_dbx_r;
      c_dby_r  <= b_dby_r;
      c_lox_r  <= posx ? SW'(b_aminx_r) - SW'(b_bmaxx_r) : SW'(b_bminx_r) - SW'(b_amaxx_r);
      c_hix_r  <= posx ? SW'(b_amaxx_r) - SW'(b_bminx_r) : SW'(b_bmaxx_r) - SW'(b_aminx_r);
      c_loy_r  <= posy ? SW'(b_aminy_r) - SW'(b_bmaxy_r) : SW'(b_bminy_r) - SW'(b_amaxy_r);
      c_hiy_r  <= posy ? SW'(b_amaxy_r) - SW'(b_bminy_r) : SW'(b_bmaxy_r) - SW'(b_aminy_r);
      c_ddx_r  <= b_dx_r[DRW-1] ? DRW'(-b_dx_r) : DRW'(b_dx_r);
      c_ddy_r  <= b_dy_r[DRW-1] ? DRW'(-b_dy_r) : DRW'(b_dy_r);
      c_dzx_r  <= dzx;
      c_dzy_r  <= dzy;
      c_sepx_r <= (b_aminx_r > b_bmaxx_r) || (b_amaxx_r < b_bminx_r);
      c_sepy_r <= (b_aminy_r > b_bmaxy_r) || (b_amaxy_r < b_bminy_r);
      c_ov_r   <= (agapx <= EW'(b_hsumx_r)) && (agapy <= EW'(b_hsumy_r));
    end
  end

  // --------------------------------------------------------------------------
  // Dividers: entry and exit time per axis; negative numerators bypass them
  // --------------------------------------------------------------------------
  logic [SW-1:0] num_sx, num_ex, num_sy, num_ey;
  logic [QW-1:0] q_sx, q_ex, q_sy, q_ey;

  assign num_sx = c_lox_r[SW-1] ? '0 : SW'(c_lox_r);
  assign num_ex = c_hix_r[SW-1] ? '0 : SW'(c_hix_r);
  assign num_sy = c_loy_r[SW-1] ? '0 : SW'(c_loy_r);
  assign num_ey = c_hiy_r[SW-1] ? '0 : SW'(c_hiy_r);

  sbc_divider u_div_sx (.clk(clk), .en(en), .num_i(num_sx), .den_i(c_ddx_r), .q_o(q_sx));
  sbc_divider u_div_ex (.clk(clk), .en(en), .num_i(num_ex), .den_i(c_ddx_r), .q_o(q_ex));
  sbc_divider u_div_sy (.clk(clk), .en(en), .num_i(num_sy), .den_i(c_ddy_r), .q_o(q_sy));
  sbc_divider u_div_ey (.clk(clk), .en(en), .num_i(num_ey), .den_i(c_ddy_r), .q_o(q_ey));

  sbc_pkg::carry_t carry_in;
  sbc_pkg::carry_t carry_r [DS];

  always_comb begin
    carry_in.pa_x        = c_pax_r;
    carry_in.pa_y        = c_pay_r;
    carry_in.pb_x        = c_pbx_r;
    carry_in.pb_y        = c_pby_r;
    carry_in.da_x        = c_dax_r;
    carry_in.da_y        = c_day_r;
    carry_in.db_x        = c_dbx_r;
    carry_in.db_y        = c_dby_r;
    carry_in.ov          = c_ov_r;
    carry_in.fail_static = (c_dzx_r && c_sepx_r) || (c_dzy_r && c_sepy_r) ||
                           (c_dzx_r && c_dzy_r);
    carry_in.act_x       = !c_dzx_r;
    carry_in.act_y       = !c_dzy_r;
    carry_in.sneg_x      = c_lox_r[SW-1];
    carry_in.eneg_x      = c_hix_r[SW-1];
    carry_in.sneg_y      = c_loy_r[SW-1];
    carry_in.eneg_y      = c_hiy_r[SW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry_r[0] <= carry_in;
      for (int k = 1; k < DS; k++) begin
        carry_r[k] <= carry_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: clamp slab times, intersect intervals, pick contact time
  // --------------------------------------------------------------------------
  sbc_pkg::carry_t cd;
  logic [QW-1:0]   sx, sy, exv, eyv, ts, te, te_x;
  logic            hit_nxt;

  assign cd   = carry_r[DS-1];
  assign sx   = (cd.act_x && !cd.sneg_x) ? q_sx : '0;
  assign sy   = (cd.act_y && !cd.sneg_y) ? q_sy : '0;
  assign exv  = cd.act_x ? q_ex : {QW{1'b1}};
  assign eyv  = cd.act_y ? q_ey : {QW{1'b1}};
  assign ts   = (sx > sy) ? sx : sy;
  assign te_x = (exv < sbc_pkg::ONE_Q16) ? exv : sbc_pkg::ONE_Q16;
  assign te   = (eyv < te_x) ? eyv : te_x;
  // a negative exit time means the pair is already moving apart on that axis
  assign hit_nxt = cd.ov || !(cd.fail_static || (cd.act_x && cd.eneg_x) ||
                              (cd.act_y && cd.eneg_y) || (ts > te));

  logic signed [PW-1:0]  e_pax_r, e_pay_r, e_pbx_r, e_pby_r;
  logic signed [DSW-1:0] e_dax_r, e_day_r, e_dbx_r, e_dby_r;
  logic                  e_hit_r;
  logic [QW-1:0]         e_t_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e_pax_r <= cd.pa_x;
      e_pay_r <= cd.pa_y;
      e_pbx_r <= cd.pb_x;
      e_pby_r <= cd.pb_y;
      e_dax_r <= cd.da_x;
      e_day_r <= cd.da_y;
      e_dbx_r <= cd.db_x;
      e_dby_r <= cd.db_y;
      e_hit_r <= hit_nxt;
      e_t_r   <= cd.ov ? '0 : ts;
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: displacement * contact time
  // --------------------------------------------------------------------------
  logic signed [QW:0]    t_s;
  logic signed [PW-1:0]  f_pax_r, f_pay_r, f_pbx_r, f_pby_r;
  logic signed [CPW-1:0] f_max_r, f_may_r, f_mbx_r, f_mby_r;
  logic                  f_hit_r;
  logic [QW-1:0]         f_t_r;

  assign t_s = $signed({1'b0, e_t_r});

  always_ff @(posedge clk) begin
    if (en) begin
      f_pax_r <= e_pax_r;
      f_pay_r <= e_pay_r;
      f_pbx_r <= e_pbx_r;
      f_pby_r <= e_pby_r;
      f_max_r <= CPW'(e_dax_r * t_s);
      f_may_r <= CPW'(e_day_r * t_s);
      f_mbx_r <= CPW'(e_dbx_r * t_s);
      f_mby_r <= CPW'(e_dby_r * t_s);
      f_hit_r <= e_hit_r;
      f_t_r   <= e_t_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: centre + floored offset, saturate, zero a miss
  // --------------------------------------------------------------------------
  function automatic logic signed [PW-1:0] contact(input logic signed [PW-1:0]  pos,
                                                   input logic signed [CPW-1:0] prod);
    logic signed [CSW-1:0] sum;
    sum = CSW'(pos) + CSW'($signed(prod[CPW-1:FW]));
    if (sum > CSW'($signed({1'b0, {(PW-1){1'b1}}}))) begin
      return {1'b0, {(PW-1){1'b1}}};
    end else if (sum < CSW'($signed({1'b1, {(PW-1){1'b0}}}))) begin
      return {1'b1, {(PW-1){1'b0}}};
    end
    return PW'(sum);
  endfunction

  logic                 g_hit_r;
  logic [QW-1:0]        g_t_r;
  logic signed [PW-1:0] g_ax_r, g_ay_r, g_bx_r, g_by_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g_hit_r <= f_hit_r;
      g_t_r   <= f_hit_r ? f_t_r : '0;
      g_ax_r  <= f_hit_r ? contact(f_pax_r, f_max_r) : '0;
      g_ay_r  <= f_hit_r ? contact(f_pay_r, f_may_r) : '0;
      g_bx_r  <= f_hit_r ? contact(f_pbx_r, f_mbx_r) : '0;
      g_by_r  <= f_hit_r ? contact(f_pby_r, f_mby_r) : '0;
    end
  end

  assign out_valid       = v_r[NSTG-1];
  assign out_hit         = g_hit_r;
  assign out_hit_time    = g_t_r;
  assign out_a_contact_x = g_ax_r;
  assign out_a_contact_y = g_ay_r;
  assign out_b_contact_x = g_bx_r;
  assign out_b_contact_y = g_by_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_time == '0 && out_a_contact_x == '0 &&
      out_a_contact_y == '0 && out_b_contact_x == '0 && out_b_contact_y == '0))
    else $error("miss result carries nonzero fields");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_hit_time <= sbc_pkg::ONE_Q16))
    else $error("hit time above 1.0");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> (v_r == $past(v_r)))
    else $error("pipeline valids moved during stall");

endmodule

FILE: sv/sbc_divider.sv
// ----------------------------------------------------------------------------
// sbc_divider: pipelined restoring divider
// Returns floor(num * 2^16 / den), saturated to all ones at 2^17 or above.
// ----------------------------------------------------------------------------
module sbc_divider (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sbc_pkg::NUM_W-1:0]   num_i,
  input  logic [sbc_pkg::DEN_W-1:0]   den_i,
  output logic [sbc_pkg::Q_W-1:0]     q_o
);

  localparam int STEPS = sbc_pkg::DIV_STEPS;
  localparam int RW    = sbc_pkg::REM_W;
  localparam int DW    = sbc_pkg::DEN_W;
  localparam int QW    = sbc_pkg::Q_W;
  localparam int NW    = sbc_pkg::NUM_W;

  logic [RW-1:0] rem_r [STEPS];
  logic [DW-1:0] den_r [STEPS];
  logic [QW-1:0] q_r   [STEPS];
  logic          sat_r [STEPS];

  genvar j;
  for (j = 0; j < STEPS; j++) begin : g_step
    logic [RW-1:0] rin;
    logic [RW-1:0] dext;
    logic [RW-1:0] rdiff;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic          sin;
    logic          bit_q;

    if (j == 0) begin : g_first
      assign rin = {{(RW-NW){1'b0}}, num_i};
      assign din = den_i;
      assign qin = '0;
      assign sin = (rin >= {den_i, 1'b0});  // quotient would need bit 17
    end else begin : g_next
      assign rin = {rem_r[j-1][RW-2:0], 1'b0};
      assign din = den_r[j-1];
      assign qin = q_r[j-1];
      assign sin = sat_r[j-1];
    end

    assign dext  = {{(RW-DW){1'b0}}, din};
    assign bit_q = (rin >= dext);
    assign rdiff = rin - dext;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= bit_q ? rdiff : rin;
        den_r[j] <= din;
        q_r[j]   <= {qin[QW-2:0], bit_q};
        sat_r[j] <= sin;
      end
    end
  end

  assign q_o = sat_r[STEPS-1] ? {QW{1'b1}} : q_r[STEPS-1];

endmodule

FILE: tb/sv/tb_swept_box_collision_unit.sv
// ----------------------------------------------------------------------------
// tb_swept_box_collision_unit: self-checking bench for the swept box unit
// Drives box pairs with bursty valid/ready traffic and a stalling receiver,
// predicts every result in a scoreboard and checks transfers in order.
// ----------------------------------------------------------------------------
module tb_swept_box_collision_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W  = sbc_pkg::POS_W;
  localparam int HALF_W = sbc_pkg::HALF_W;
  localparam int VEL_W  = sbc_pkg::VEL_W;
  localparam int Q_W    = sbc_pkg::Q_W;
  localparam int DT_W   = sbc_pkg::DT_W;
  localparam logic [DT_W-1:0] DT_RESET = sbc_pkg::DT_RESET;

  localparam int LATENCY   = 23;
  localparam int DRAIN_CYC = LATENCY + 10;
  localparam int CYC_LIMIT = 600000;
  localparam int N_RANDOM  = 1900;

  typedef struct {
    logic signed [POS_W-1:0] a_pos_x, a_pos_y;
    logic [HALF_W-1:0]       a_half_x, a_half_y;
    logic signed [VEL_W-1:0] a_vel_x, a_vel_y;
    logic signed [POS_W-1:0] b_pos_x, b_pos_y;
    logic [HALF_W-1:0]       b_half_x, b_half_y;
    logic signed [VEL_W-1:0] b_vel_x, b_vel_y;
  } box_pair_t;

  typedef struct {
    logic                    hit;
    logic [Q_W-1:0]          hit_time;
    logic signed [POS_W-1:0] a_cx, a_cy, b_cx, b_cy;
  } contact_t;

  // Scoreboard: holds its own copy of dt and the queue of pending contacts.
  class contact_scoreboard;
    longint unsigned dt;
    contact_t        pending[$];
    int              mismatches;

    function new();
      dt = DT_RESET;
      mismatches = 0;
    endfunction

    function longint shr16_floor(longint v);
      if (v >= 0) return v >>> 16;
      return -((-v + 65535) >>> 16);
    endfunction

    function longint div_floor(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q -= 1;
      return q;
    endfunction

    function logic [POS_W-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[POS_W-1:0];
    endfunction

    // slab test on one axis; a moving axis narrows [ts,te], a static one checks overlap; returns 0 when empty
    function bit slab(longint d, longint amin, longint amax, longint bmin,
                      longint bmax, inout longint ts, inout longint te);
      longint lo, hi, dd, s, e;
      if (d == 0) return !(amin > bmax || amax < bmin);
      if (d > 0) begin
        lo = amin - bmax; hi = amax - bmin; dd = d;
      end else begin
        lo = bmin - amax; hi = bmax - amin; dd = -d;
      end
      s = div_floor(lo * 65536, dd);
      e = div_floor(hi * 65536, dd);
      if (s > ts) ts = s;
      if (e < te) te = e;
      return ts <= te;
    endfunction

    function contact_t predict(box_pair_t p);
      contact_t r;
      longint pax, pay, hax, hay, pbx, pby, hbx, hby;
      longint dax, day, dbx, dby, dx, dy, ex, ey, ts, te, sdt;
      r = '{hit: 0, hit_time: 0, a_cx: 0, a_cy: 0, b_cx: 0, b_cy: 0};
      pax = p.a_pos_x; pay = p.a_pos_y; pbx = p.b_pos_x; pby = p.b_pos_y;
      hax = {33'd0, p.a_half_x}; hay = {33'd0, p.a_half_y};
      hbx = {33'd0, p.b_half_x}; hby = {33'd0, p.b_half_y};
      sdt = longint'(dt);
      ex = pax - pbx; if (ex < 0) ex = -ex;
      ey = pay - pby; if (ey < 0) ey = -ey;
      if (ex <= hax + hbx && ey <= hay + hby) begin
        r.hit = 1;
        r.a_cx = clamp32(pax); r.a_cy = clamp32(pay);
        r.b_cx = clamp32(pbx); r.b_cy = clamp32(pby);
        return r;
      end
      dax = shr16_floor(longint'(p.a_vel_x) * sdt);
      day = shr16_floor(longint'(p.a_vel_y) * sdt);
      dbx = shr16_floor(longint'(p.b_vel_x) * sdt);
      dby = shr16_floor(longint'(p.b_vel_y) * sdt);
      dx = dbx - dax;
      dy = dby - day;
      if (dx == 0 && dy == 0) return r;
      ts = 0;
      te = 65536;
      if (!slab(dx, pax - hax, pax + hax, pbx - hbx, pbx + hbx, ts, te)) return r;
      if (!slab(dy, pay - hay, pay + hay, pby - hby, pby + hby, ts, te)) return r;
      r.hit = 1;
      r.hit_time = ts[Q_W-1:0];
      r.a_cx = clamp32(pax + shr16_floor(dax * ts));
      r.a_cy = clamp32(pay + shr16_floor(day * ts));
      r.b_cx = clamp32(pbx + shr16_floor(dbx * ts));
      r.b_cy = clamp32(pby + shr16_floor(dby * ts));
      return r;
    endfunction

    function void note_input(box_pair_t p);
      pending.push_back(predict(p));
    endfunction

    function void check_result(contact_t got);
      contact_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit || got.hit_time !== want.hit_time ||
          got.a_cx !== want.a_cx || got.a_cy !== want.a_cy ||
          got.b_cx !== want.b_cx || got.b_cy !== want.b_cy) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: exp hit=%0d t=%0d a=(%0d,%0d) b=(%0d,%0d)",
                   $realtime, want.hit, want.hit_time, want.a_cx, want.a_cy,
                   want.b_cx, want.b_cy);
          $display("  got hit=%0d t=%0d a=(%0d,%0d) b=(%0d,%0d)",
                   got.hit, got.hit_time, got.a_cx, got.a_cy, got.b_cx, got.b_cy);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [DT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_ready;
  box_pair_t drv = '{default: '0};
  logic out_valid;
  logic out_ready = 0;
  logic out_hit;
  logic [Q_W-1:0] out_hit_time;
  logic signed [POS_W-1:0] out_a_contact_x, out_a_contact_y;
  logic signed [POS_W-1:0] out_b_contact_x, out_b_contact_y;

  contact_scoreboard sb = new();
  int cycles = 0;
  int stall_mode = 0;

  always #6 clk = ~clk;

  swept_box_collision_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_pos_x(drv.a_pos_x), .in_a_pos_y(drv.a_pos_y),
    .in_a_half_x(drv.a_half_x), .in_a_half_y(drv.a_half_y),
    .in_a_vel_x(drv.a_vel_x), .in_a_vel_y(drv.a_vel_y),
    .in_b_pos_x(drv.b_pos_x), .in_b_pos_y(drv.b_pos_y),
    .in_b_half_x(drv.b_half_x), .in_b_half_y(drv.b_half_y),
    .in_b_vel_x(drv.b_vel_x), .in_b_vel_y(drv.b_vel_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_hit_time(out_hit_time),
    .out_a_contact_x(out_a_contact_x), .out_a_contact_y(out_a_contact_y),
    .out_b_contact_x(out_b_contact_x), .out_b_contact_y(out_b_contact_y)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("tb_swept_box_collision_unit: errors");
      $finish;
    end
  end

  // receiver: picks one of four stall patterns at random, including no-stall runs
  always @(negedge clk) begin
    if (cycles % 300 == 0) stall_mode <= int'($urandom_range(0, 3));
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) != 0);
      2: out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= ((cycles % 11) < 4);
    endcase
  end

  // result monitor: a transfer is valid && ready at the rising edge
  always @(posedge clk) begin
    contact_t got;
    if (rst_n && out_valid && out_ready) begin
      got.hit = out_hit;
      got.hit_time = out_hit_time;
      got.a_cx = out_a_contact_x; got.a_cy = out_a_contact_y;
      got.b_cx = out_b_contact_x; got.b_cy = out_b_contact_y;
      sb.check_result(got);
    end
  end

  function automatic int span(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic box_pair_t pair(int pax, int pay, int hax, int hay, int vax,
                                     int vay, int pbx, int pby, int hbx, int hby,
                                     int vbx, int vby);
    box_pair_t p;
    p.a_pos_x = pax; p.a_pos_y = pay; p.a_half_x = HALF_W'(hax);
    p.a_half_y = HALF_W'(hay);
    p.a_vel_x = vax; p.a_vel_y = vay; p.b_pos_x = pbx; p.b_pos_y = pby;
    p.b_half_x = HALF_W'(hbx); p.b_half_y = HALF_W'(hby);
    p.b_vel_x = vbx; p.b_vel_y = vby;
    return p;
  endfunction

  // mostly near-miss scenes that sweep into contact; some lines, some noise
  function automatic box_pair_t random_pair();
    box_pair_t p;
    int kind;
    kind = $urandom_range(0, 9);
    p = pair(span(1 << 22), span(1 << 22), $urandom_range(0, 1 << 19),
             $urandom_range(0, 1 << 19), span(1 << 22), span(1 << 22),
             span(1 << 22), span(1 << 22), $urandom_range(0, 1 << 19),
             $urandom_range(0, 1 << 19), span(1 << 22), span(1 << 22));
    case (kind)
      0, 1: begin
        p.a_pos_x = $urandom; p.a_pos_y = $urandom; p.b_pos_x = $urandom;
        p.b_pos_y = $urandom; p.a_vel_x = $urandom; p.a_vel_y = $urandom;
        p.b_vel_x = $urandom; p.b_vel_y = $urandom;
        p.a_half_x = HALF_W'($urandom); p.a_half_y = HALF_W'($urandom);
        p.b_half_x = HALF_W'($urandom); p.b_half_y = HALF_W'($urandom);
        if (kind == 1) begin
          p.a_half_x >>= $urandom_range(0, 30); p.a_half_y >>= $urandom_range(0, 30);
          p.b_half_x >>= $urandom_range(0, 30); p.b_half_y >>= $urandom_range(0, 30);
        end
      end
      2: begin  // fixed line segment
        if ($urandom_range(0, 1)) p.b_half_x = 0; else p.b_half_y = 0;
        p.b_vel_x = 0; p.b_vel_y = 0;
      end
      3: begin  // one static axis
        p.b_vel_y = p.a_vel_y;
      end
      4: begin  // contact near the upper rail
        p.a_pos_x = 32'sh7FF00000 + span(1 << 19);
        p.a_vel_x = 32'sh7FFFFFFF - $urandom_range(0, 1 << 20);
        p.b_pos_x = p.a_pos_x + 32'sh00080000;
      end
      default: ;
    endcase
    return p;
  endfunction

  // one item per call; valid stays high, the caller drops it when idle
  task automatic send_pair(box_pair_t p);
    in_valid <= 1'b1;
    drv <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_input(p);
    @(negedge clk);
  endtask

  task automatic drain_and_write(logic [DT_W-1:0] dt);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= dt;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.dt = dt;
  endtask

  task automatic random_phase(int n);
    int left, burst, gap;
    bit holdoff;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_pair(random_pair());
        left--;
      end
      holdoff = ($urandom_range(0, 40) == 0);
      if (gap > 0 || holdoff || left == 0) in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      // hold-off: let the pipeline run dry mid-phase once in a while
      if (holdoff)
        while (sb.pending.size() != 0) @(negedge clk);
    end
  endtask

  initial begin
    box_pair_t directed[$];
    logic [DT_W-1:0] dts[6];
    directed.push_back(pair(0, 0, 65536, 65536, 0, 0, 65536, 0, 32768, 32768, 0, 0));
    // touching edges now
    directed.push_back(pair(0, 0, 65536, 65536, 0, 0, 131072, 0, 65536, 65536, 0, 0));
    // no relative motion, apart
    directed.push_back(pair(0, 0, 65536, 65536, 65536, 0, 1 << 22, 0, 65536, 65536,
                            65536, 0));
    // approach along x, hit mid step
    directed.push_back(pair(0, 0, 65536, 65536, 0, 0, 1 << 20, 0, 65536, 65536,
                            -(1 << 21), 0));
    // touching at end of step
    directed.push_back(pair(0, 0, 65536, 65536, 0, 0, 6 << 16, 0, 65536, 65536,
                            -(4 << 16), 0));
    // static y axis separated
    directed.push_back(pair(0, 0, 65536, 65536, 0, 0, 1 << 20, 1 << 22, 65536, 65536,
                            -(1 << 21), 0));
    // moving away
    directed.push_back(pair(0, 0, 65536, 65536, 0, 0, 1 << 20, 0, 65536, 65536,
                            1 << 21, 0));
    // vertical and horizontal fixed lines
    directed.push_back(pair(0, 0, 65536, 65536, 1 << 21, 0, 1 << 20, 0, 0, 1 << 20, 0, 0));
    directed.push_back(pair(0, 0, 65536, 65536, 0, -(1 << 21), 0, -(1 << 20), 1 << 20,
                            0, 0, 0));
    // extremes of every field
    directed.push_back(pair(32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                            31'h7FFFFFFF, 31'h7FFFFFFF, 32'h80000000, 32'h80000000));
    directed.push_back(pair(32'h80000000, 32'h80000000, 0, 0, 32'h80000000,
                            32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0,
                            32'h7FFFFFFF, 32'h7FFFFFFF));
    directed.push_back(pair(32'h80000000, 0, 0, 0, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 0, 0,
                            0, 32'h80000000, 0));
    // contact centre clamps at the rails
    directed.push_back(pair(32'h7FF00000, 0, 0, 65536, 32'h7FFFFFFF, 0,
                            32'h7FFF0000, 0, 0, 65536, 32'h80000000, 0));
    directed.push_back(pair(32'h80100000, 0, 0, 65536, 32'h80000000, 0,
                            32'h80000000, 0, 0, 65536, 32'h7FFFFFFF, 0));
    // diagonal approach, both axes moving
    directed.push_back(pair(0, 0, 65536, 65536, 1 << 20, 1 << 20, 1 << 21, 1 << 21,
                            65536, 65536, -(1 << 20), -(1 << 20)));
    dts = '{24'd65536, 24'd0, 24'hFFFFFF, 24'd1, 24'd32768, 24'd0};
    dts[5] = DT_W'($urandom_range(2, 24'hFFFFFE));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset value first, then every setting in turn
    foreach (directed[i]) send_pair(directed[i]);
    random_phase(N_RANDOM / 4);
    for (int k = 1; k < 6; k++) begin
      drain_and_write(dts[k]);
      foreach (directed[i]) send_pair(directed[i]);
      random_phase(N_RANDOM / 8);
    end
    drain_and_write(24'd65536);
    random_phase(N_RANDOM / 10);

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_swept_box_collision_unit: clean");
    end else begin
      $display("tb_swept_box_collision_unit: errors");
    end
    $finish;
  end

endmodule

FILE: swept_box_collision_unit.f
sv/sbc_pkg.sv
sv/sbc_divider.sv
sv/swept_box_collision_unit.sv
tb/sv/tb_swept_box_collision_unit.sv
